/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scanline timer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg
// Types, timing constants and mode codes for the LCD scanline mode timer.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int LINE_CYCLES    = 456;
    localparam int VISIBLE_LINES  = 144;
    localparam int LAST_LINE      = 153;
    localparam int OAM_SEARCH_MIN = 376;
    localparam int TRANSFER_MIN   = 204;

    // Countdown width follows from the reload value.
    localparam int CNT_W = $clog2(LINE_CYCLES + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // Bit positions inside status_irq_enables.
    localparam int IRQ_EN_HBLANK = 0;
    localparam int IRQ_EN_VBLANK = 1;
    localparam int IRQ_EN_OAM    = 2;
    localparam int IRQ_EN_COIN   = 3;

    typedef struct packed {
        logic [3:0] status_irq_enables;
        logic [7:0] line_compare;
        logic       lcd_enable;
        logic [5:0] elapsed_cycles;
    } item_t;

    typedef struct packed {
        logic       vram_access;
        logic       oam_access;
        logic       frame_done;
        logic [7:0] render_line;
        logic       render_strobe;
        logic       vblank_irq;
        logic       stat_irq;
        logic       coincidence;
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
    } result_t;

endpackage

/* rtl/lst_in_stage.sv */
// ----------------------------------------------------------------------------
// lst_in_stage
// Input register: holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module lst_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lst_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            advance,
    output logic                            item_valid,
    output lst_pkg::item_t                  item
);

    logic           vld_reg;
    logic           vld_next;
    lst_pkg::item_t item_reg;
    logic           take;

    assign s_tready   = !vld_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= lst_pkg::item_t'(s_tdata[$bits(lst_pkg::item_t)-1:0]);
        end
    end

endmodule

/* rtl/lst_core.sv */
// ----------------------------------------------------------------------------
// lst_core
// Line countdown, line counter and mode state with the per-request update.
// ----------------------------------------------------------------------------
module lst_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  lst_pkg::item_t   item,
    output lst_pkg::result_t result
);

    logic [lst_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                line_reg, line_next;
    logic [1:0]                mode_reg, mode_next;
    logic                      coin_reg, coin_next;
    logic                      oam_reg, oam_next;
    logic                      vram_reg, vram_next;

    logic [lst_pkg::CNT_W-1:0] elapsed_ext;
    logic [lst_pkg::CNT_W-1:0] remain;
    logic                      line_end;
    logic [8:0]                line_inc;
    logic                      mode_change;

    assign elapsed_ext = lst_pkg::CNT_W'(item.elapsed_cycles);
    // The countdown never sits at zero, so line end means elapsed covers it.
    assign line_end    = (count_reg <= elapsed_ext);
    assign remain      = count_reg - elapsed_ext;
    assign line_inc    = {1'b0, line_reg} + 9'd1;

    always_comb begin
        count_next  = count_reg;
        line_next   = line_reg;
        mode_next   = mode_reg;
        coin_next   = coin_reg;
        oam_next    = oam_reg;
        vram_next   = vram_reg;
        mode_change = 1'b0;
        result      = '0;

        if (!item.lcd_enable) begin
            count_next = lst_pkg::CNT_W'(lst_pkg::LINE_CYCLES);
            line_next  = 8'd0;
            mode_next  = lst_pkg::MODE_VBLANK;
            coin_next  = 1'b0;
            oam_next   = 1'b1;
            vram_next  = 1'b1;
        end else begin
            if ({1'b0, line_reg} >= 9'(lst_pkg::VISIBLE_LINES)) begin
                mode_next = lst_pkg::MODE_VBLANK;
            end else if (!line_end && remain >= lst_pkg::CNT_W'(lst_pkg::OAM_SEARCH_MIN)) begin
                mode_next = lst_pkg::MODE_OAM;
            end else if (!line_end && remain >= lst_pkg::CNT_W'(lst_pkg::TRANSFER_MIN)) begin
                mode_next = lst_pkg::MODE_XFER;
            end else begin
                mode_next = lst_pkg::MODE_HBLANK;
            end

            mode_change = (mode_next != mode_reg);
            if (mode_change) begin
                unique case (mode_next)
                    lst_pkg::MODE_HBLANK: begin
                        result.stat_irq = item.status_irq_enables[lst_pkg::IRQ_EN_HBLANK];
                    end
                    lst_pkg::MODE_VBLANK: begin
                        result.vblank_irq = 1'b1;
                        result.stat_irq   = item.status_irq_enables[lst_pkg::IRQ_EN_VBLANK];
                    end
                    lst_pkg::MODE_OAM: begin
                        result.stat_irq = item.status_irq_enables[lst_pkg::IRQ_EN_OAM];
                    end
                    default: begin
                        result.stat_irq = 1'b0;
                    end
                endcase
            end

            oam_next  = (mode_next == lst_pkg::MODE_HBLANK) ||
                        (mode_next == lst_pkg::MODE_VBLANK);
            vram_next = (mode_next != lst_pkg::MODE_XFER);

            coin_next = (line_reg == item.line_compare);
            if (coin_next && !coin_reg && item.status_irq_enables[lst_pkg::IRQ_EN_COIN]) begin
                result.stat_irq = 1'b1;
            end

            if (line_end) begin
                if ({1'b0, line_reg} < 9'(lst_pkg::VISIBLE_LINES)) begin
                    result.render_strobe = 1'b1;
                    result.render_line   = line_reg;
                end
                result.frame_done = (line_inc == 9'(lst_pkg::VISIBLE_LINES));
                if (line_inc > 9'(lst_pkg::LAST_LINE)) begin
                    line_next = 8'd0;
                end else begin
                    line_next = line_inc[7:0];
                end
                count_next = lst_pkg::CNT_W'(lst_pkg::LINE_CYCLES);
            end else begin
                count_next = remain;
            end
        end

        result.current_line = line_next;
        result.lcd_mode     = mode_next;
        result.coincidence  = coin_next;
        result.oam_access   = oam_next;
        result.vram_access  = vram_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= lst_pkg::CNT_W'(lst_pkg::LINE_CYCLES);
            line_reg  <= 8'd0;
            mode_reg  <= lst_pkg::MODE_VBLANK;
            coin_reg  <= 1'b0;
            oam_reg   <= 1'b1;
            vram_reg  <= 1'b1;
        end else if (advance) begin
            count_reg <= count_next;
            line_reg  <= line_next;
            mode_reg  <= mode_next;
            coin_reg  <= coin_next;
            oam_reg   <= oam_next;
            vram_reg  <= vram_next;
        end
    end

endmodule

/* rtl/lst_out_stage.sv */
// ----------------------------------------------------------------------------
// lst_out_stage
// Result register that presents one finished result on the master side.
// ----------------------------------------------------------------------------
module lst_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  lst_pkg::result_t                result,
    output logic                            out_free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lst_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic             vld_reg;
    logic             vld_next;
    lst_pkg::result_t res_reg;

    assign out_free = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = lst_pkg::OUT_TDATA_W'(res_reg);

    always_comb begin
        if (advance) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

endmodule

/* rtl/lcd_scanline_mode_timer_top.sv */
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_top
// LCD scanline timer: line countdown, line counter, mode, status interrupts.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid/s_tready    elapsed, enable, compare, irq enables
//   m_        out        m_tvalid/m_tready    line, mode, flags, pulses, render line
//
// Every request yields exactly one result. A request is registered on
// acceptance; once the result register is free, the core updates its line
// state and forms the result, and the result register captures it and offers
// it on the master side. One request is taken every cycle while the result is
// not stalled. The line state feeds back through one subtract and a few
// compares. Reset (aresetn low, synchronous) empties both stages and returns
// the timer to line 0, vertical blank, full countdown. A stalled result holds
// in the output register while one more request waits in the input register;
// beyond that s_tready drops.
//
// The LCD enable low forces the timer back to its reset state for that
// request and suppresses every pulse. Mode follows standard thresholds on
// the countdown after the elapsed cycles are taken off; interrupts fire
// only on entry to a mode or on a rising coincidence, gated by the enables.
// A line end drops any surplus cycles and advances only a single line.
module lcd_scanline_mode_timer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] elapsed_cycles, [6] lcd_enable, [14:7] line_compare,
    // [18:15] status_irq_enables, [23:19] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] current_line, [9:8] lcd_mode, [10] coincidence, [11] stat_irq,
    // [12] vblank_irq, [13] render_strobe, [21:14] render_line,
    // [22] frame_done, [23] oam_access, [24] vram_access, [31:25] zero
    output logic [31:0] m_tdata
);

    lst_pkg::item_t   item;
    lst_pkg::result_t result;
    logic             item_valid;
    logic             out_free;
    logic             advance;

    // The core moves a request forward whenever the result register can take it.
    assign advance = item_valid && out_free;

    lst_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lst_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    lst_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/lst_checker.sv */
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks on the scanline timer results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic       s_unused;
    logic [1:0] mode;

    assign s_unused = s_tvalid ^ s_tready ^ (^s_tdata);
    assign mode     = m_tdata[9:8];

    // A stalled result stays put.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready && !s_unused | s_unused, m_tvalid && $stable(m_tdata))

    // Access flags agree with the reported mode.
    `ASSERT_IMPLIES(a_access, aclk, aresetn, m_tvalid, (m_tdata[24] == (mode != lst_pkg::MODE_XFER)) && (m_tdata[23] == ((mode == lst_pkg::MODE_HBLANK) || (mode == lst_pkg::MODE_VBLANK))))

    // The render line is zero unless a line was just finished.
    `ASSERT_IMPLIES(a_render, aclk, aresetn, m_tvalid && !m_tdata[13], m_tdata[21:14] == 8'd0)

    // Frame done comes with a render strobe and lands on the first vertical blank line.
    `ASSERT_IMPLIES(a_frame, aclk, aresetn, m_tvalid && m_tdata[22], (m_tdata[7:0] == 8'(lst_pkg::VISIBLE_LINES)) && m_tdata[13])

    // The vertical blank pulse only comes with the vertical blank mode.
    `ASSERT_IMPLIES(a_vblank, aclk, aresetn, m_tvalid && m_tdata[12], mode == lst_pkg::MODE_VBLANK)

endmodule

bind lcd_scanline_mode_timer_top lst_checker u_lst_checker (.*);
